// ----- design/lcr_pkg.sv -----
// Shared types and constants for the four-point Lagrange resampler.
// No dependencies; the datapath, sequencer, top level and testbench refer to this package.
`default_nettype none

package lcr_pkg;

	localparam int MAX_SAMPLES_DEF = 1024;
	localparam logic [23:0] MAX_OUTPUTS = 24'd16777215;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_PRODUCE = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	localparam logic [2:0] STS_OK         = 3'd0;
	localparam logic [2:0] STS_BAD_CFG    = 3'd1;
	localparam logic [2:0] STS_FEW        = 3'd2;
	localparam logic [2:0] STS_STORE_FULL = 3'd3;
	localparam logic [2:0] STS_RUN_DONE   = 3'd4;
	localparam logic [2:0] STS_NO_WINDOW  = 3'd5;

	localparam logic CFG_START_TIME  = 1'b0;
	localparam logic CFG_OUTPUT_STEP = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_APPLY, S_TOT_A, S_TOT_AW, S_TOT_B, S_TOT_BW, S_TOT_C, S_CHECK,
		S_TIME, S_EDGE1, S_EDGE2, S_SRCH_A, S_SRCH_B, S_WIN_START, S_WIN_STEP,
		S_DEGEN, S_FAC_MUL, S_FAC_DIV, S_FAC_DW, S_FAC_W, S_ACC_MUL, S_ACC_ADD,
		S_ROUND, S_FIN, S_DONE
	} ctrl_state_t;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_ACCEPT, CMD_APPLY, CMD_TOT_A, CMD_TOT_B, CMD_TOT_C, CMD_CHECK,
		CMD_TIME, CMD_EDGE1, CMD_EDGE2, CMD_SRCH_A, CMD_SRCH_B, CMD_WIN_START,
		CMD_WIN_STEP, CMD_DEGEN, CMD_FAC_MUL, CMD_FAC_DIV, CMD_FAC_W, CMD_ACC_MUL,
		CMD_ACC_ADD, CMD_ROUND, CMD_FIN, CMD_OUT
	} dp_cmd_t;

	typedef struct packed {
		logic is_prod;
		logic tot_zero;
		logic chk_fail;
		logic lt1;
		logic out_hi;
		logic srch_none;
		logic hit;
		logic srch_end;
		logic win_last;
		logic degen;
		logic div_done;
		logic j_last;
		logic k_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- design/lcr_ifs.sv -----
// Channel interfaces of the resampler: request, response and register write.
// Payload widths are fixed by the item format; no package dependency.
`default_nettype none

interface lcr_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [31:0]        sample_time;
	logic signed [31:0] sample_value;
	modport source (output valid, opcode, sample_time, sample_value, input ready);
	modport sink (input valid, opcode, sample_time, sample_value, output ready);
endinterface

interface lcr_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [31:0]        out_time;
	logic signed [31:0] out_value;
	logic [23:0]        out_index;
	logic               out_last;
	logic [23:0]        point_total;
	modport source (output valid, status, out_time, out_value, out_index, out_last,
		point_total, input ready);
	modport sink (input valid, status, out_time, out_value, out_index, out_last,
		point_total, output ready);
endinterface

interface lcr_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/lcr_div.sv -----
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, 32 quotient bits.
// Flags overflow when the quotient needs more than 32 bits. No package use.
`default_nettype none

module lcr_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quot,
	output logic             ovf
);

	logic [5:0]  cnt_q;
	logic        done_q;
	logic [31:0] rem_q;
	logic [31:0] lo_q;
	logic [31:0] dsr_q;
	logic        ovf_q;
	logic [32:0] trial;
	logic        ge;

	assign trial = {rem_q, lo_q[31]};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 6'd32;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[63:32];
			lo_q  <= dividend[31:0];
			dsr_q <= divisor;
			ovf_q <= dividend[63:32] >= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
			lo_q  <= {lo_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign quot = lo_q;
	assign ovf  = ovf_q;

endmodule

`default_nettype wire

// ----- design/lcr_dp.sv -----
// Datapath of the resampler: sample store, run registers, window, weights, output.
// Uses lcr_pkg for commands and status codes; instantiates lcr_div.
`default_nettype none

module lcr_dp #(
	parameter int MAX_SAMPLES = lcr_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lcr_pkg::dp_cmd_t   cmd,
	output lcr_pkg::dp_stat_t       stat,
	input  wire logic [1:0]         opcode,
	input  wire logic [31:0]        sample_time,
	input  wire logic signed [31:0] sample_value,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [31:0]        cfg_data,
	output logic [2:0]              status,
	output logic [31:0]             out_time,
	output logic signed [31:0]      out_value,
	output logic [23:0]             out_index,
	output logic                    out_last,
	output logic [23:0]             point_total
);

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int CX = CW + 1;

	logic [31:0] time_mem [MAX_SAMPLES];
	logic [31:0] val_mem [MAX_SAMPLES];

	logic [1:0]  op_q;
	logic [31:0] itime_q;
	logic [31:0] ival_q;
	logic [31:0] tdat_q;
	logic [31:0] vdat_q;

	logic [CW-1:0] cnt_q;
	logic [23:0]   total_q;
	logic [23:0]   ocnt_q;
	logic [AW-1:0] sidx_q;
	logic [31:0]   start_q;
	logic [31:0]   step_q;

	logic [31:0]        first_q;
	logic [31:0]        last_q;
	logic [AW-1:0]      i_q;
	logic [AW-1:0]      base_q;
	logic [1:0]         wi_q;
	logic [31:0]        cur_q;
	logic               lt1_q;
	logic               ge_q;
	logic [31:0]        tw_q [4];
	logic [31:0]        vw_q [4];
	logic [1:0]         k_q;
	logic [1:0]         j_q;
	logic signed [31:0] w_q;
	logic               neg_q;
	logic [31:0]        den_q;
	logic [63:0]        prod_s1;
	logic signed [63:0] pv_s1;
	logic [55:0]        pt_s1;
	logic signed [57:0] acc_q;
	logic [2:0]         sts_q;
	logic [31:0]        rt_q;
	logic [31:0]        rv_q;
	logic [23:0]        ri_q;
	logic               rl_q;

	logic          is_load;
	logic          is_prod;
	logic          full;
	logic          tot_zero;
	logic [31:0]   span;
	logic [32:0]   sum33;
	logic [2:0]    chk;
	logic [56:0]   tsum;
	logic [31:0]   tsat;
	logic [AW-1:0] n_m2;
	logic [AW-1:0] n_m4;
	logic          srch_none;
	logic          srch_end;
	logic          hit;
	logic          out_hi;
	logic          degen;
	logic [AW-1:0] rd_addr;
	logic          mem_we;

	logic          div_start;
	logic [63:0]   div_dnd;
	logic [31:0]   div_dsr;
	logic          div_done;
	logic [31:0]   dquot;
	logic          dovf;

	logic signed [32:0] num;
	logic signed [32:0] den;
	logic [31:0]        mag_num;
	logic [31:0]        mag_den;
	logic [31:0]        mag_w;
	logic [63:0]        m_prod;
	logic signed [31:0] sv;
	logic signed [63:0] pv_prod;
	logic [31:0]        w_new;
	logic [2:0]         j_inc;
	logic [2:0]         j_nxt;
	logic signed [57:0] rnd;
	logic signed [57:0] rnd_sh;
	logic [31:0]        rnd_sat;

	assign is_load  = op_q == lcr_pkg::OP_LOAD;
	assign is_prod  = op_q == lcr_pkg::OP_PRODUCE;
	assign full     = cnt_q == CW'(MAX_SAMPLES);
	assign tot_zero = (cnt_q < CW'(4)) || (step_q == '0);
	assign span     = (last_q >= first_q) ? (last_q - first_q) : '0;
	assign sum33    = {1'b0, span} + {1'b0, dquot};

	always_comb begin
		if (start_q == '0 || step_q == '0) begin
			chk = lcr_pkg::STS_BAD_CFG;
		end else if (cnt_q < CW'(4)) begin
			chk = lcr_pkg::STS_FEW;
		end else if (ocnt_q >= total_q) begin
			chk = lcr_pkg::STS_RUN_DONE;
		end else begin
			chk = lcr_pkg::STS_OK;
		end
	end

	// Target time saturates at the top of the time range.
	assign tsum = {25'd0, start_q} + {1'b0, pt_s1};
	assign tsat = (tsum[56:32] != '0) ? '1 : tsum[31:0];

	assign n_m2      = AW'(cnt_q - CW'(2));
	assign n_m4      = AW'(cnt_q - CW'(4));
	assign srch_none = (CX'(sidx_q) + CX'(4)) > CX'(cnt_q);
	assign srch_end  = (CX'(i_q) + CX'(5)) > CX'(cnt_q);
	assign hit       = ge_q && (cur_q <= tdat_q);
	assign out_hi    = cur_q > tdat_q;
	assign degen     = (tw_q[0] == tw_q[1]) || (tw_q[0] == tw_q[2]) ||
		(tw_q[0] == tw_q[3]) || (tw_q[1] == tw_q[2]) || (tw_q[1] == tw_q[3]) ||
		(tw_q[2] == tw_q[3]);

	always_comb begin
		case (cmd)
			lcr_pkg::CMD_TIME:      rd_addr = AW'(1);
			lcr_pkg::CMD_EDGE1:     rd_addr = n_m2;
			lcr_pkg::CMD_EDGE2:     rd_addr = sidx_q + AW'(1);
			lcr_pkg::CMD_SRCH_A:    rd_addr = i_q + AW'(2);
			lcr_pkg::CMD_SRCH_B:    rd_addr = i_q + AW'(2);
			lcr_pkg::CMD_WIN_START: rd_addr = base_q;
			lcr_pkg::CMD_WIN_STEP:  rd_addr = base_q + AW'(wi_q) + AW'(1);
			default:                rd_addr = '0;
		endcase
	end

	assign mem_we = (cmd == lcr_pkg::CMD_APPLY) && is_load && !full;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			time_mem[cnt_q[AW-1:0]] <= itime_q;
			val_mem[cnt_q[AW-1:0]]  <= ival_q;
		end
		tdat_q <= time_mem[rd_addr];
		vdat_q <= val_mem[rd_addr];
	end

	// Shared divider: run total and the twelve weight factors.
	always_comb begin
		div_start = 1'b0;
		div_dnd   = prod_s1;
		div_dsr   = den_q;
		case (cmd)
			lcr_pkg::CMD_TOT_A: begin
				div_start = !tot_zero;
				div_dnd   = {32'd0, span};
				div_dsr   = 32'(cnt_q);
			end
			lcr_pkg::CMD_TOT_B: begin
				div_start = 1'b1;
				div_dnd   = 64'(sum33);
				div_dsr   = step_q;
			end
			lcr_pkg::CMD_FAC_DIV: begin
				div_start = 1'b1;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	lcr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dnd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quot     (dquot),
		.ovf      (dovf)
	);

	assign num     = $signed({1'b0, cur_q}) - $signed({1'b0, tw_q[j_q]});
	assign den     = $signed({1'b0, tw_q[k_q]}) - $signed({1'b0, tw_q[j_q]});
	assign mag_num = num[32] ? 32'(-num) : num[31:0];
	assign mag_den = den[32] ? 32'(-den) : den[31:0];
	assign mag_w   = w_q[31] ? (~w_q + 32'd1) : w_q;
	assign m_prod  = mag_w * mag_num;
	assign sv      = $signed(vw_q[k_q]);
	assign pv_prod = sv * w_q;

	always_comb begin
		if (neg_q) begin
			w_new = (dovf || dquot > 32'h8000_0000) ? 32'h8000_0000 : (~dquot + 32'd1);
		end else begin
			w_new = (dovf || dquot[31]) ? 32'h7FFF_FFFF : dquot;
		end
	end

	// Step to the next factor, skipping the weight's own sample.
	assign j_inc = {1'b0, j_q} + 3'd1;
	assign j_nxt = (j_inc == {1'b0, k_q}) ? (j_inc + 3'd1) : j_inc;

	assign rnd     = acc_q + 58'sd2097152;
	assign rnd_sh  = rnd >>> 22;
	assign rnd_sat = (rnd_sh[57:31] == '0 || rnd_sh[57:31] == '1) ? rnd_sh[31:0] :
		(rnd_sh[57] ? 32'h8000_0000 : 32'h7FFF_FFFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			total_q <= '0;
			ocnt_q  <= '0;
			sidx_q  <= '0;
			start_q <= '0;
			step_q  <= '0;
		end else begin
			case (cmd)
				lcr_pkg::CMD_APPLY: begin
					if (is_load && !full) begin
						cnt_q  <= cnt_q + CW'(1);
						ocnt_q <= '0;
						sidx_q <= '0;
					end else if (op_q == lcr_pkg::OP_CLEAR) begin
						cnt_q  <= '0;
						ocnt_q <= '0;
						sidx_q <= '0;
					end
				end
				lcr_pkg::CMD_TOT_A: begin
					if (tot_zero) begin
						total_q <= '0;
					end
				end
				lcr_pkg::CMD_TOT_C: begin
					total_q <= (dovf || dquot > 32'(lcr_pkg::MAX_OUTPUTS)) ?
						lcr_pkg::MAX_OUTPUTS : dquot[23:0];
				end
				lcr_pkg::CMD_SRCH_B: begin
					if (hit) begin
						sidx_q <= i_q;
					end
				end
				lcr_pkg::CMD_FIN: begin
					ocnt_q <= ocnt_q + 24'd1;
				end
				default: begin
				end
			endcase
			if (cfg_we) begin
				if (cfg_index == lcr_pkg::CFG_START_TIME) begin
					start_q <= cfg_data;
				end else begin
					step_q <= cfg_data;
				end
				ocnt_q <= '0;
				sidx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			lcr_pkg::CMD_ACCEPT: begin
				op_q    <= opcode;
				itime_q <= sample_time;
				ival_q  <= sample_value;
			end
			lcr_pkg::CMD_APPLY: begin
				sts_q <= (is_load && full) ? lcr_pkg::STS_STORE_FULL : lcr_pkg::STS_OK;
				rt_q  <= '0;
				rv_q  <= '0;
				ri_q  <= '0;
				rl_q  <= 1'b0;
				if (is_load && !full) begin
					if (cnt_q == '0) begin
						first_q <= itime_q;
					end
					last_q <= itime_q;
				end
			end
			lcr_pkg::CMD_CHECK: begin
				if (is_prod) begin
					sts_q <= chk;
				end
				pt_s1 <= ocnt_q * step_q;
			end
			lcr_pkg::CMD_TIME: begin
				cur_q <= tsat;
			end
			lcr_pkg::CMD_EDGE1: begin
				lt1_q <= cur_q < tdat_q;
			end
			lcr_pkg::CMD_EDGE2: begin
				if (lt1_q) begin
					base_q <= '0;
				end else if (out_hi) begin
					base_q <= n_m4;
				end else if (srch_none) begin
					sts_q <= lcr_pkg::STS_NO_WINDOW;
				end
				i_q <= sidx_q;
			end
			lcr_pkg::CMD_SRCH_A: begin
				ge_q <= cur_q >= tdat_q;
			end
			lcr_pkg::CMD_SRCH_B: begin
				if (hit) begin
					base_q <= i_q;
				end else if (srch_end) begin
					sts_q <= lcr_pkg::STS_NO_WINDOW;
				end else begin
					i_q <= i_q + AW'(1);
				end
			end
			lcr_pkg::CMD_WIN_START: begin
				wi_q <= '0;
			end
			lcr_pkg::CMD_WIN_STEP: begin
				tw_q[wi_q] <= tdat_q;
				vw_q[wi_q] <= vdat_q;
				wi_q       <= wi_q + 2'd1;
			end
			lcr_pkg::CMD_DEGEN: begin
				if (degen) begin
					sts_q <= lcr_pkg::STS_NO_WINDOW;
				end
				k_q   <= 2'd0;
				j_q   <= 2'd1;
				w_q   <= 32'sh4000_0000;
				acc_q <= '0;
			end
			lcr_pkg::CMD_FAC_MUL: begin
				prod_s1 <= m_prod;
				neg_q   <= w_q[31] ^ num[32] ^ den[32];
				den_q   <= mag_den;
			end
			lcr_pkg::CMD_FAC_W: begin
				w_q <= w_new;
				j_q <= j_nxt[1:0];
			end
			lcr_pkg::CMD_ACC_MUL: begin
				pv_s1 <= pv_prod;
			end
			lcr_pkg::CMD_ACC_ADD: begin
				acc_q <= acc_q + 58'(pv_s1 >>> 8);
				k_q   <= k_q + 2'd1;
				j_q   <= 2'd0;
				w_q   <= 32'sh4000_0000;
			end
			lcr_pkg::CMD_ROUND: begin
				rv_q <= rnd_sat;
			end
			lcr_pkg::CMD_FIN: begin
				rt_q <= cur_q;
				ri_q <= ocnt_q;
				rl_q <= (ocnt_q + 24'd1) == total_q;
			end
			lcr_pkg::CMD_OUT: begin
				status      <= sts_q;
				out_time    <= rt_q;
				out_value   <= rv_q;
				out_index   <= ri_q;
				out_last    <= rl_q;
				point_total <= total_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.is_prod   = is_prod;
		stat.tot_zero  = tot_zero;
		stat.chk_fail  = chk != lcr_pkg::STS_OK;
		stat.lt1       = lt1_q;
		stat.out_hi    = out_hi;
		stat.srch_none = srch_none;
		stat.hit       = hit;
		stat.srch_end  = srch_end;
		stat.win_last  = wi_q == 2'd3;
		stat.degen     = degen;
		stat.div_done  = div_done;
		stat.j_last    = j_nxt[2];
		stat.k_last    = k_q == 2'd3;
	end

endmodule

`default_nettype wire

// ----- design/lcr_ctrl.sv -----
// Sequencer of the resampler: one item at a time through the datapath commands.
// Uses lcr_pkg for states, commands and the datapath status struct.
`default_nettype none

module lcr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire lcr_pkg::dp_stat_t stat,
	output lcr_pkg::dp_cmd_t       cmd
);

	lcr_pkg::ctrl_state_t state_q;
	lcr_pkg::ctrl_state_t state_nxt;
	logic                 out_valid_q;
	logic                 slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lcr_pkg::S_IDLE:      if (in_valid) state_nxt = lcr_pkg::S_APPLY;
			lcr_pkg::S_APPLY:     state_nxt = lcr_pkg::S_TOT_A;
			lcr_pkg::S_TOT_A:     state_nxt = stat.tot_zero ? lcr_pkg::S_CHECK :
				lcr_pkg::S_TOT_AW;
			lcr_pkg::S_TOT_AW:    if (stat.div_done) state_nxt = lcr_pkg::S_TOT_B;
			lcr_pkg::S_TOT_B:     state_nxt = lcr_pkg::S_TOT_BW;
			lcr_pkg::S_TOT_BW:    if (stat.div_done) state_nxt = lcr_pkg::S_TOT_C;
			lcr_pkg::S_TOT_C:     state_nxt = lcr_pkg::S_CHECK;
			lcr_pkg::S_CHECK:     state_nxt = (stat.is_prod && !stat.chk_fail) ?
				lcr_pkg::S_TIME : lcr_pkg::S_DONE;
			lcr_pkg::S_TIME:      state_nxt = lcr_pkg::S_EDGE1;
			lcr_pkg::S_EDGE1:     state_nxt = lcr_pkg::S_EDGE2;
			lcr_pkg::S_EDGE2: begin
				if (stat.lt1 || stat.out_hi) begin
					state_nxt = lcr_pkg::S_WIN_START;
				end else if (stat.srch_none) begin
					state_nxt = lcr_pkg::S_FIN;
				end else begin
					state_nxt = lcr_pkg::S_SRCH_A;
				end
			end
			lcr_pkg::S_SRCH_A:    state_nxt = lcr_pkg::S_SRCH_B;
			lcr_pkg::S_SRCH_B: begin
				if (stat.hit) begin
					state_nxt = lcr_pkg::S_WIN_START;
				end else if (stat.srch_end) begin
					state_nxt = lcr_pkg::S_FIN;
				end else begin
					state_nxt = lcr_pkg::S_SRCH_A;
				end
			end
			lcr_pkg::S_WIN_START: state_nxt = lcr_pkg::S_WIN_STEP;
			lcr_pkg::S_WIN_STEP:  if (stat.win_last) state_nxt = lcr_pkg::S_DEGEN;
			lcr_pkg::S_DEGEN:     state_nxt = stat.degen ? lcr_pkg::S_FIN :
				lcr_pkg::S_FAC_MUL;
			lcr_pkg::S_FAC_MUL:   state_nxt = lcr_pkg::S_FAC_DIV;
			lcr_pkg::S_FAC_DIV:   state_nxt = lcr_pkg::S_FAC_DW;
			lcr_pkg::S_FAC_DW:    if (stat.div_done) state_nxt = lcr_pkg::S_FAC_W;
			lcr_pkg::S_FAC_W:     state_nxt = stat.j_last ? lcr_pkg::S_ACC_MUL :
				lcr_pkg::S_FAC_MUL;
			lcr_pkg::S_ACC_MUL:   state_nxt = lcr_pkg::S_ACC_ADD;
			lcr_pkg::S_ACC_ADD:   state_nxt = stat.k_last ? lcr_pkg::S_ROUND :
				lcr_pkg::S_FAC_MUL;
			lcr_pkg::S_ROUND:     state_nxt = lcr_pkg::S_FIN;
			lcr_pkg::S_FIN:       state_nxt = lcr_pkg::S_DONE;
			lcr_pkg::S_DONE:      if (slot_free) state_nxt = lcr_pkg::S_IDLE;
			default:              state_nxt = lcr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			lcr_pkg::S_IDLE:      cmd = in_valid ? lcr_pkg::CMD_ACCEPT : lcr_pkg::CMD_NONE;
			lcr_pkg::S_APPLY:     cmd = lcr_pkg::CMD_APPLY;
			lcr_pkg::S_TOT_A:     cmd = lcr_pkg::CMD_TOT_A;
			lcr_pkg::S_TOT_B:     cmd = lcr_pkg::CMD_TOT_B;
			lcr_pkg::S_TOT_C:     cmd = lcr_pkg::CMD_TOT_C;
			lcr_pkg::S_CHECK:     cmd = lcr_pkg::CMD_CHECK;
			lcr_pkg::S_TIME:      cmd = lcr_pkg::CMD_TIME;
			lcr_pkg::S_EDGE1:     cmd = lcr_pkg::CMD_EDGE1;
			lcr_pkg::S_EDGE2:     cmd = lcr_pkg::CMD_EDGE2;
			lcr_pkg::S_SRCH_A:    cmd = lcr_pkg::CMD_SRCH_A;
			lcr_pkg::S_SRCH_B:    cmd = lcr_pkg::CMD_SRCH_B;
			lcr_pkg::S_WIN_START: cmd = lcr_pkg::CMD_WIN_START;
			lcr_pkg::S_WIN_STEP:  cmd = lcr_pkg::CMD_WIN_STEP;
			lcr_pkg::S_DEGEN:     cmd = lcr_pkg::CMD_DEGEN;
			lcr_pkg::S_FAC_MUL:   cmd = lcr_pkg::CMD_FAC_MUL;
			lcr_pkg::S_FAC_DIV:   cmd = lcr_pkg::CMD_FAC_DIV;
			lcr_pkg::S_FAC_W:     cmd = lcr_pkg::CMD_FAC_W;
			lcr_pkg::S_ACC_MUL:   cmd = lcr_pkg::CMD_ACC_MUL;
			lcr_pkg::S_ACC_ADD:   cmd = lcr_pkg::CMD_ACC_ADD;
			lcr_pkg::S_ROUND:     cmd = lcr_pkg::CMD_ROUND;
			lcr_pkg::S_FIN:       cmd = lcr_pkg::CMD_FIN;
			lcr_pkg::S_DONE:      cmd = slot_free ? lcr_pkg::CMD_OUT : lcr_pkg::CMD_NONE;
			default:              cmd = lcr_pkg::CMD_NONE;
		endcase
		in_ready  = state_q == lcr_pkg::S_IDLE;
		out_valid = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcr_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == lcr_pkg::S_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The divider finishes only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == lcr_pkg::S_TOT_AW || state_q == lcr_pkg::S_TOT_BW ||
		state_q == lcr_pkg::S_FAC_DW))
	else $error("divider done outside a wait state");

	// A stalled result is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> cmd != lcr_pkg::CMD_OUT)
	else $error("pending result overwritten");

	// Every transfer into the block starts the apply step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == lcr_pkg::S_APPLY)
	else $error("accepted item not applied");

	// A result is posted only at the end of an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == lcr_pkg::S_DONE)
	else $error("result posted outside done state");

endmodule

`default_nettype wire

// ----- design/lagrange_cubic_resampler.sv -----
// Top level of the four-point Lagrange resampler: ties sequencer and datapath.
// Depends on lcr_pkg, lcr_ifs, lcr_ctrl, lcr_dp and lcr_div.
//
// Use: write start_time (index 0) and output_step (index 1) on cfg while idle;
// each write restarts the output run. On req, opcode 0 loads a sample into
// the store, 1 requests the next resampled point, 2 clears the store, 3 does
// nothing. Every request item gives exactly one response item on rsp, with a
// status code and the current point total.
// Flow: an item is taken in the idle state only. Every item first recomputes
// the point total with two passes of the shared divider; with fewer than
// four samples or a zero step the divider is skipped. A produce request that
// reaches a point then finds its window, searching where needed, and runs
// twelve weight factors, each through one multiply and one division on the
// same divider. Items do not overlap: the next item is taken once the last
// has left the done step, while its result may still wait on rsp, and a
// stalled rsp holds the finished item in the done step until the output
// register frees.
// Reset clears the sample count, run position, point total and registers;
// the sample store holds stale data, which is never read below the count.
`default_nettype none

module lagrange_cubic_resampler #(
	parameter int MAX_SAMPLES = lcr_pkg::MAX_SAMPLES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	lcr_req_if.sink   req,
	lcr_rsp_if.source rsp,
	lcr_cfg_if.sink   cfg
);

	lcr_pkg::dp_cmd_t  cmd;
	lcr_pkg::dp_stat_t stat;
	logic              cfg_we;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid;

	lcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lcr_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (req.opcode),
		.sample_time  (req.sample_time),
		.sample_value (req.sample_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.status       (rsp.status),
		.out_time     (rsp.out_time),
		.out_value    (rsp.out_value),
		.out_index    (rsp.out_index),
		.out_last     (rsp.out_last),
		.point_total  (rsp.point_total)
	);

endmodule

`default_nettype wire

// ----- tb/tb_lagrange_cubic_resampler.sv -----
// Self-checking testbench for the four-point Lagrange resampler.
// Depends on lcr_pkg, lcr_ifs and the lagrange_cubic_resampler top level.
// A bit-true predictor tracks every accepted request and checks each response.
`timescale 1ns / 100ps

module tb_lagrange_cubic_resampler;
	import lcr_pkg::*;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int STORE_DEPTH = 1024;
	localparam int ITEM_GOAL = 1100;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] out_time;
		logic [31:0] out_value;
		logic [23:0] out_index;
		logic        out_last;
		logic [23:0] point_total;
	} point_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lcr_req_if req_ch();
	lcr_rsp_if rsp_ch();
	lcr_cfg_if cfg_ch();

	lagrange_cubic_resampler u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [31:0] times_mdl [STORE_DEPTH];
	logic [31:0] values_mdl [STORE_DEPTH];
	int unsigned sample_cnt;
	int unsigned run_total;
	int unsigned run_pos;
	int unsigned win_pos;
	logic [31:0] start_reg;
	logic [31:0] step_reg;

	point_rsp_t pending_rsp[$];
	int errors = 0;
	int items_sent = 0;
	bit drop_bursts = 1'b0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int unsigned points_in_run();
		longint unsigned span, q;
		span = 0;
		if (sample_cnt < 4 || step_reg == 0)
			return 0;
		if (times_mdl[sample_cnt-1] >= times_mdl[0])
			span = longint'(times_mdl[sample_cnt-1]) - longint'(times_mdl[0]);
		q = (span + span / sample_cnt) / step_reg;
		if (q > MAX_OUTPUTS)
			q = MAX_OUTPUTS;
		return int'(q);
	endfunction

	function automatic longint lagrange_weight(input logic [31:0] x, input int unsigned base,
			input int i, inout bit degen);
		longint w, num, den;
		longint unsigned q, mw, mn, md;
		bit neg;
		w = longint'(1) <<< 30;
		for (int j = 0; j < 4; j++) begin
			if (j == i)
				continue;
			num = longint'({32'b0, x}) - longint'({32'b0, times_mdl[base+j]});
			den = longint'({32'b0, times_mdl[base+i]}) - longint'({32'b0, times_mdl[base+j]});
			if (den == 0) begin
				degen = 1'b1;
				return 0;
			end
			neg = (w < 0) ^ (num < 0) ^ (den < 0);
			mw = (w < 0) ? -w : w;
			mn = (num < 0) ? -num : num;
			md = (den < 0) ? -den : den;
			q = (mw * mn) / md;
			if (neg) begin
				if (q > 64'h8000_0000)
					q = 64'h8000_0000;
				w = -longint'(q);
			end else begin
				if (q > 64'h7FFF_FFFF)
					q = 64'h7FFF_FFFF;
				w = longint'(q);
			end
		end
		return w;
	endfunction

	function automatic point_rsp_t predict_point(input logic [1:0] op, input logic [31:0] t_in,
			input logic [31:0] v_in);
		point_rsp_t r;
		longint unsigned t;
		longint acc, w, oval;
		logic [31:0] cur;
		int unsigned base;
		bit found, degen;
		r = '{default: '0};
		oval = 0;
		case (op)
			OP_LOAD: begin
				if (sample_cnt >= STORE_DEPTH) begin
					r.status = STS_STORE_FULL;
				end else begin
					times_mdl[sample_cnt] = t_in;
					values_mdl[sample_cnt] = v_in;
					sample_cnt++;
					run_pos = 0;
					win_pos = 0;
				end
			end
			OP_CLEAR: begin
				sample_cnt = 0;
				run_pos = 0;
				win_pos = 0;
			end
			OP_PRODUCE: begin
				run_total = points_in_run();
				if (start_reg == 0 || step_reg == 0) begin
					r.status = STS_BAD_CFG;
				end else if (sample_cnt < 4) begin
					r.status = STS_FEW;
				end else if (run_pos >= run_total) begin
					r.status = STS_RUN_DONE;
				end else begin
					t = longint'(start_reg) + longint'(run_pos) * longint'(step_reg);
					if (t > 64'hFFFF_FFFF)
						t = 64'hFFFF_FFFF;
					cur = t[31:0];
					base = 0;
					found = 1'b1;
					degen = 1'b0;
					if (cur < times_mdl[1]) begin
						base = 0;
					end else if (cur > times_mdl[sample_cnt-2]) begin
						base = sample_cnt - 4;
					end else begin
						found = 1'b0;
						for (int unsigned i = win_pos; i + 4 <= sample_cnt; i++) begin
							if (cur >= times_mdl[i+1] && cur <= times_mdl[i+2]) begin
								base = i;
								win_pos = i;
								found = 1'b1;
								break;
							end
						end
					end
					if (found) begin
						acc = 0;
						for (int k = 0; k < 4 && !degen; k++) begin
							w = lagrange_weight(cur, base, k, degen);
							acc += (longint'(signed'(values_mdl[base+k])) * w) >>> 8;
						end
						if (!degen) begin
							oval = (acc + (longint'(1) <<< 21)) >>> 22;
							if (oval > 64'sh7FFF_FFFF)
								oval = 64'sh7FFF_FFFF;
							if (oval < -64'sh8000_0000)
								oval = -64'sh8000_0000;
						end
					end
					if (!found || degen) begin
						r.status = STS_NO_WINDOW;
						oval = 0;
					end
					r.out_time = cur;
					r.out_index = run_pos[23:0];
					r.out_last = (run_pos + 1 == run_total);
					run_pos++;
				end
			end
			default: ;
		endcase
		r.out_value = oval[31:0];
		r.point_total = points_in_run();
		return r;
	endfunction

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (drop_bursts || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [31:0] t_in, input logic [31:0] v_in);
		int gap;
		gap = gap_cycles();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.opcode = op;
		req_ch.sample_time = t_in;
		req_ch.sample_value = v_in;
		req_ch.valid = 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_rsp.push_back(predict_point(op, t_in, v_in));
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
	endtask

	// hold until idle, then write one register
	task automatic write_reg(input logic idx, input logic [31:0] val);
		drain();
		cfg_ch.index = idx;
		cfg_ch.data = val;
		cfg_ch.valid = 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		if (idx == CFG_START_TIME)
			start_reg = val;
		else
			step_reg = val;
		run_pos = 0;
		win_pos = 0;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// receiver stall pattern, with stall-free stretches
	initial begin
		int n;
		forever begin
			n = $urandom_range(0, 99);
			@(negedge clk);
			if (drop_bursts || n < 70) begin
				rsp_ch.ready = 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end else begin
				rsp_ch.ready = 1'b0;
				repeat ((n < 95) ? $urandom_range(1, 4) : $urandom_range(20, 120)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		point_rsp_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				report("unexpected transfer", {29'b0, rsp_ch.status}, 32'b0);
			end else begin
				e = pending_rsp.pop_front();
				if (rsp_ch.status !== e.status)
					report("status", {29'b0, rsp_ch.status}, {29'b0, e.status});
				if (rsp_ch.out_time !== e.out_time)
					report("out_time", rsp_ch.out_time, e.out_time);
				if (rsp_ch.out_value !== e.out_value)
					report("out_value", rsp_ch.out_value, e.out_value);
				if (rsp_ch.out_index !== e.out_index)
					report("out_index", {8'b0, rsp_ch.out_index}, {8'b0, e.out_index});
				if (rsp_ch.out_last !== e.out_last)
					report("out_last", {31'b0, rsp_ch.out_last}, {31'b0, e.out_last});
				if (rsp_ch.point_total !== e.point_total)
					report("point_total", {8'b0, rsp_ch.point_total}, {8'b0, e.point_total});
			end
		end
	end

	task automatic produce_n(input int n);
		for (int i = 0; i < n; i++)
			send_item(OP_PRODUCE, $urandom, $urandom);
	endtask

	task automatic test_bad_setup();
		produce_n(1);
		send_item(OP_LOAD, 32'h0001_0000, 32'h7FFF_FFFF);
		send_item(OP_LOAD, 32'h0002_0000, 32'h8000_0000);
		produce_n(1);
		write_reg(CFG_START_TIME, 32'h0001_8000);
		produce_n(1);
		write_reg(CFG_OUTPUT_STEP, 32'h0000_4000);
		produce_n(1);
		send_item(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_CLEAR, 32'h0, 32'h0);
	endtask

	task automatic test_extremes();
		send_item(OP_LOAD, 32'h0, 32'h7FFF_FFFF);
		send_item(OP_LOAD, 32'h4000_0000, 32'h8000_0000);
		send_item(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
		send_item(OP_LOAD, 32'hFFFF_FFFF, 32'h8000_0000);
		write_reg(CFG_START_TIME, 32'hF000_0000);
		write_reg(CFG_OUTPUT_STEP, 32'h8000_0000);
		// second point runs past the time range and saturates
		produce_n(3);
		write_reg(CFG_START_TIME, 32'h0000_0001);
		write_reg(CFG_OUTPUT_STEP, 32'hFFFF_FFFF);
		produce_n(2);
		// equal times inside the window
		send_item(OP_CLEAR, 32'h0, 32'h0);
		send_item(OP_LOAD, 32'h0001_0000, 32'h0001_0000);
		send_item(OP_LOAD, 32'h0002_0000, 32'h0002_0000);
		send_item(OP_LOAD, 32'h0002_0000, 32'h0003_0000);
		send_item(OP_LOAD, 32'h0004_0000, 32'h0004_0000);
		write_reg(CFG_START_TIME, 32'h0001_0000);
		write_reg(CFG_OUTPUT_STEP, 32'h0000_8000);
		produce_n(3);
		// unordered times: search may fail
		send_item(OP_LOAD, 32'h0000_8000, 32'hFFFF_0000);
		produce_n(4);
		send_item(OP_CLEAR, 32'h0, 32'h0);
	endtask

	task automatic test_store_full();
		logic [31:0] t;
		t = 32'h0000_1000;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			send_item(OP_LOAD, t, $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000);
			t += $urandom_range(1, 32'h0000_2000);
		end
		send_item(OP_LOAD, 32'hFFFF_FFFF, 32'h1234_5678);
		write_reg(CFG_START_TIME, 32'h0000_1800);
		write_reg(CFG_OUTPUT_STEP, (t - 32'h0000_1000) / 6);
		produce_n(9);
		send_item(OP_CLEAR, 32'h0, 32'h0);
	endtask

	task automatic test_random_runs();
		int n, total, kind;
		logic [31:0] t0, t, span, v;
		longint unsigned nt;
		while (items_sent < ITEM_GOAL) begin
			send_item(OP_CLEAR, $urandom, $urandom);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
			kind = $urandom_range(0, 9);
			t0 = (kind == 0) ? $urandom : $urandom_range(1, 32'h0100_0000);
			t = t0;
			for (int i = 0; i < n; i++) begin
				v = (kind < 3) ? $urandom : $urandom_range(0, 32'h007F_FFFF) - 32'h0040_0000;
				send_item(OP_LOAD, t, v);
				case ($urandom_range(0, 19))
					0: nt = t;
					1: nt = (t > 32'h0001_0000) ? t - 32'h0001_0000 : 0;
					default: nt = longint'(t) + ((kind == 0) ? $urandom : $urandom_range(1, 32'h0003_0000));
				endcase
				t = (nt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nt[31:0];
			end
			span = (t > t0) ? t - t0 : 32'h0001_0000;
			write_reg(CFG_START_TIME, ($urandom_range(0, 3) == 0) ? $urandom :
				t0 + $urandom_range(0, span / 4) + 1);
			write_reg(CFG_OUTPUT_STEP, span / $urandom_range(3, 30) + 1);
			total = points_in_run();
			drop_bursts = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < total + 1 && i < 40; i++) begin
				if ($urandom_range(0, 29) == 0)
					drain();
				send_item(($urandom_range(0, 39) == 0) ? OP_NOP : OP_PRODUCE, $urandom, $urandom);
			end
			drop_bursts = 1'b0;
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_NOP;
		req_ch.sample_time = '0;
		req_ch.sample_value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_START_TIME;
		cfg_ch.data = '0;
		rsp_ch.ready = 1'b0;
		sample_cnt = 0;
		run_total = 0;
		run_pos = 0;
		win_pos = 0;
		start_reg = '0;
		step_reg = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		test_bad_setup();
		test_extremes();
		test_store_full();
		test_random_runs();
		drain();
		repeat (600) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
